// ===== hdl/assert_macros.svh =====
// Assertion macros used by the pair stream decoder job queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("assertion failed");

// The antecedent implies the consequent at the same clock edge.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

`endif

// ===== hdl/dcpsd_pkg.sv =====
// Package with the types, constants and functions of the pair stream decoder.
package dcpsd_pkg;
	localparam logic [22:0] MAX_PAIRS = 23'd8000000;
	localparam logic [3:0] CODE_MASK = 4'hF;
	localparam logic [1:0] REG_POINTER_SIZE = 2'd0;
	localparam logic [1:0] REG_PAIR_COUNT = 2'd1;
	localparam logic [1:0] PH_TYPE = 2'd0;
	localparam logic [1:0] PH_ID = 2'd1;
	localparam logic [1:0] PH_OFFSET = 2'd2;

	localparam logic [2:0] CODE_ABS8 = 3'd0;
	localparam logic [2:0] CODE_INC = 3'd1;
	localparam logic [2:0] CODE_ADD_B = 3'd2;
	localparam logic [2:0] CODE_SUB_B = 3'd3;
	localparam logic [2:0] CODE_ADD_W = 3'd4;
	localparam logic [2:0] CODE_SUB_W = 3'd5;
	localparam logic [2:0] CODE_ABS_W = 3'd6;

	typedef struct packed {
		logic err;
		logic [31:0] id;
		logic [63:0] val;
		logic [2:0] code;
		logic scaled;
		logic final_pair;
	} job_t;

	function automatic logic [3:0] field_len(input logic [2:0] code);
		logic [3:0] n;
		case (code)
			CODE_ABS8: n = 4'd8;
			CODE_INC: n = 4'd0;
			CODE_ADD_B, CODE_SUB_B: n = 4'd1;
			CODE_ADD_W, CODE_SUB_W, CODE_ABS_W: n = 4'd2;
			default: n = 4'd4;
		endcase
		return n;
	endfunction

	function automatic logic [63:0] take_field(input logic [3:0] n, input logic [63:0] acc);
		logic [63:0] v;
		case (n)
			4'd1: v = {56'd0, acc[63:56]};
			4'd2: v = {48'd0, acc[63:48]};
			4'd4: v = {32'd0, acc[63:32]};
			default: v = acc;
		endcase
		return v;
	endfunction

	function automatic logic [63:0] apply_code(input logic [2:0] code, input logic [63:0] base,
			input logic [63:0] v);
		logic [63:0] r;
		case (code)
			CODE_INC: r = base + 64'd1;
			CODE_ADD_B, CODE_ADD_W: r = base + v;
			CODE_SUB_B, CODE_SUB_W: r = base - v;
			default: r = v;
		endcase
		return r;
	endfunction
endpackage

// ===== hdl/dcpsd_front.sv =====
// Front part: takes bytes, assembles fields, decodes ids and issues pair jobs.
module dcpsd_front import dcpsd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic [7:0] stream_byte,
	input logic [22:0] pair_count,
	output logic push,
	output job_t job
);
	logic [1:0] phase_q;
	logic [7:0] type_q;
	logic [3:0] left_q;
	logic [63:0] acc_q;
	logic [63:0] new_id_q;
	logic [63:0] prev_id_q;
	logic [22:0] done_q;
	logic halted_q;

	logic active;
	logic [63:0] acc_nx;
	logic [3:0] left_nx;
	logic [63:0] id_nx;
	logic [22:0] done_inc;
	logic [2:0] id_code;
	logic [2:0] off_code;
	logic [7:0] tc;

	assign active = !halted_q && (pair_count != 23'd0) && (pair_count <= MAX_PAIRS) &&
		(done_q < pair_count);
	assign acc_nx = {stream_byte, acc_q[63:8]};
	assign left_nx = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
	assign done_inc = done_q + 23'd1;
	assign tc = (phase_q == PH_ID || phase_q == PH_OFFSET) ? type_q : stream_byte;
	assign id_code = tc[2:0];
	assign off_code = tc[6:4];

	always_comb begin
		id_nx = new_id_q;
		push = 1'b0;
		job.err = 1'b0;
		job.id = 32'd0;
		job.val = 64'd0;
		job.code = off_code;
		job.scaled = tc[7];
		job.final_pair = (done_inc == pair_count);
		if (fire && active) begin
			if (phase_q == PH_ID || phase_q == PH_OFFSET) begin
				if (left_nx == 4'd0) begin
					if (phase_q == PH_ID) begin
						id_nx = apply_code(id_code, prev_id_q,
							take_field(field_len(id_code), acc_nx));
						push = (field_len(off_code) == 4'd0);
					end else begin
						push = 1'b1;
						job.val = take_field(field_len(off_code), acc_nx);
					end
				end
			end else if ((stream_byte[3:0] & CODE_MASK) > 4'd7) begin
				push = 1'b1;
				job.err = 1'b1;
				job.final_pair = 1'b0;
			end else if (field_len(id_code) == 4'd0) begin
				id_nx = prev_id_q + 64'd1;
				push = (field_len(off_code) == 4'd0);
			end
		end
		job.id = job.err ? 32'd0 : id_nx[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			type_q <= 8'd0;
			left_q <= 4'd0;
			acc_q <= 64'd0;
			new_id_q <= 64'd0;
			prev_id_q <= 64'd0;
			done_q <= 23'd0;
			halted_q <= 1'b0;
		end else if (fire && active) begin
			new_id_q <= id_nx;
			if (phase_q == PH_ID || phase_q == PH_OFFSET) begin
				acc_q <= acc_nx;
				left_q <= left_nx;
				if (left_nx == 4'd0 && phase_q == PH_ID && !push) begin
					phase_q <= PH_OFFSET;
					left_q <= field_len(off_code);
					acc_q <= 64'd0;
				end
			end else begin
				type_q <= stream_byte;
				if (job.err) begin
					halted_q <= 1'b1;
					phase_q <= PH_TYPE;
				end else if (field_len(id_code) == 4'd0) begin
					if (!push) begin
						phase_q <= PH_OFFSET;
						left_q <= field_len(off_code);
						acc_q <= 64'd0;
					end
				end else begin
					phase_q <= PH_ID;
					left_q <= field_len(id_code);
					acc_q <= 64'd0;
				end
			end
			if (push && !job.err) begin
				done_q <= done_inc;
				prev_id_q <= id_nx;
				phase_q <= PH_TYPE;
				left_q <= 4'd0;
			end
		end
	end
endmodule

// ===== hdl/dcpsd_queue.sv =====
// Two-entry job queue between the front and back parts.
module dcpsd_queue import dcpsd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t wr_job,
	input logic pop,
	output job_t rd_job,
	output logic full,
	output logic empty
);
	`include "assert_macros.svh"

	job_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full)
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty)
	`ASSERT_IMPLY(a_count_range, clk, arst_n, 1'b1, cnt_q <= 2'd2)
endmodule

// ===== hdl/dcpsd_back.sv =====
// Back part: computes offsets, scaled ones with the divide and scale path, and holds the result.
module dcpsd_back import dcpsd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input job_t job,
	input logic [7:0] pointer_size,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] entry_id,
	output logic [31:0] entry_offset,
	output logic status,
	output logic final_pair
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV = 5'b00010,
		ST_CALC = 5'b00100,
		ST_MUL = 5'b01000,
		ST_OUT = 5'b10000
	} state_t;

	state_t state_q;
	job_t job_q;
	logic [63:0] prev_off_q;
	logic [63:0] dvd_q;
	logic [7:0] rem_q;
	logic [5:0] cnt_q;
	logic [63:0] off_q;
	logic [7:0] ps;
	logic [8:0] rem_sh;
	logic rem_ge;
	logic [71:0] prod;
	logic [63:0] off_calc;

	assign ps = (pointer_size == 8'd0) ? 8'd1 : pointer_size;
	assign rem_sh = {rem_q, dvd_q[63]};
	assign rem_ge = (rem_sh >= {1'b0, ps});
	assign prod = off_q * ps;
	assign off_calc = apply_code(job_q.code, dvd_q, job_q.val);
	assign pop = (state_q == ST_IDLE) && !empty;
	assign out_valid = (state_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q <= '0;
			prev_off_q <= 64'd0;
			dvd_q <= 64'd0;
			rem_q <= 8'd0;
			cnt_q <= 6'd0;
			off_q <= 64'd0;
			entry_id <= 32'd0;
			entry_offset <= 32'd0;
			status <= 1'b0;
			final_pair <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						job_q <= job;
						dvd_q <= prev_off_q;
						rem_q <= 8'd0;
						cnt_q <= 6'd0;
						if (job.err) begin
							entry_id <= 32'd0;
							entry_offset <= 32'd0;
							status <= 1'b1;
							final_pair <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							state_q <= job.scaled ? ST_DIV : ST_CALC;
						end
					end
				end
				ST_DIV: begin
					rem_q <= rem_ge ? 8'(rem_sh - {1'b0, ps}) : rem_sh[7:0];
					dvd_q <= {dvd_q[62:0], rem_ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= ST_CALC;
				end
				ST_CALC: begin
					off_q <= off_calc;
					state_q <= job_q.scaled ? ST_MUL : ST_OUT;
					if (!job_q.scaled) begin
						prev_off_q <= off_calc;
						entry_offset <= off_calc[31:0];
					end
					entry_id <= job_q.id;
					status <= 1'b0;
					final_pair <= job_q.final_pair;
				end
				ST_MUL: begin
					prev_off_q <= prod[63:0];
					entry_offset <= prod[31:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/delta_coded_pair_stream_decoder_unit.sv =====
// Top level of the delta coded pair stream decoder.
// A completing byte's job passes the job queue and the back part's idle, calc and out
// states (div and mul around calc when scaled); an invalid id code goes idle to out.
// Throughput: one byte per cycle while the two-entry job queue has room.
// The back part pops a pair only when idle; scaled ones use the 64-step offset divider.
// Reset clears all decode state, sets pointer_size to 8 and pair_count to 1.
module delta_coded_pair_stream_decoder_unit import dcpsd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] stream_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] entry_id,
	output logic [31:0] entry_offset,
	output logic status,
	output logic final_pair,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [22:0] cfg_data
);
	logic [7:0] pointer_size_q;
	logic [22:0] pair_count_q;
	logic push;
	logic pop;
	logic full;
	logic empty;
	job_t wr_job;
	job_t rd_job;

	assign cfg_ready = 1'b1;
	assign in_stall = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_size_q <= 8'd8;
			pair_count_q <= 23'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POINTER_SIZE: pointer_size_q <= cfg_data[7:0];
				REG_PAIR_COUNT: pair_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dcpsd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.fire(in_valid && !in_stall),
		.stream_byte(stream_byte),
		.pair_count(pair_count_q),
		.push(push),
		.job(wr_job)
	);

	dcpsd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_job(wr_job),
		.pop(pop),
		.rd_job(rd_job),
		.full(full),
		.empty(empty)
	);

	dcpsd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.job(rd_job),
		.pointer_size(pointer_size_q),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.entry_id(entry_id),
		.entry_offset(entry_offset),
		.status(status),
		.final_pair(final_pair)
	);
endmodule
